// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Command and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int DEF_BUCKETS   = 7;
    localparam int DEF_POOL_SIZE = 64;
    localparam int DEF_KEY_WIDTH = 32;

    // Result word: found, status, bucket packed from bit 0, padded to a byte.
    localparam int RES_W = 8;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_SEARCH = 2'd1;
    localparam cmd_t CMD_DELETE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STAT_DONE      = 2'd0;
    localparam status_t STAT_NOT_FOUND = 2'd1;
    localparam status_t STAT_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_DECIDE,
        ST_POP,
        ST_WALK,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/cht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// cht_mod_unit: remainder of a key by the bucket count
// Reciprocal multiplication by a constant, then one multiply-back correction.
// ----------------------------------------------------------------------------
module cht_mod_unit
    import cht_pkg::*;
#(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int BUCKETS   = DEF_BUCKETS,
    localparam int BW       = $clog2(BUCKETS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] dividend,
    output logic                 done,
    output logic [BW-1:0]        remainder
);

    // The quotient is (key * MAGIC) >> (KEY_WIDTH + BW), exact for every key
    // because MAGIC = ceil(2^(KEY_WIDTH + BW) / BUCKETS) and 2^BW >= BUCKETS.
    localparam int SW  = KEY_WIDTH + BW + 1;
    localparam int PRW = 2 * KEY_WIDTH + 1;
    localparam logic [SW-1:0]      POW2    = SW'(1) << (KEY_WIDTH + BW);
    localparam logic [SW-1:0]      DIV_W   = SW'(BUCKETS);
    localparam logic [SW-1:0]      MAGIC_W = (POW2 + DIV_W - SW'(1)) / DIV_W;
    localparam logic [KEY_WIDTH:0] MAGIC   = MAGIC_W[KEY_WIDTH:0];
    localparam logic [BW-1:0]      DIV_LOW = BW'(BUCKETS);

    logic [KEY_WIDTH-1:0] x_reg;
    logic [PRW-1:0]       prod_reg;
    logic                 mul_reg;
    logic                 fix_reg;
    logic                 done_reg;
    logic [BW-1:0]        rem_reg;
    logic [BW-1:0]        q_low;
    logic [BW-1:0]        qd_low;
    logic [BW-1:0]        rem_calc;

    // The remainder is below 2^BW, so only the low bits of key - q * BUCKETS
    // are needed.
    assign q_low    = prod_reg[KEY_WIDTH + BW +: BW];
    assign qd_low   = BW'(q_low * DIV_LOW);
    assign rem_calc = x_reg[BW-1:0] - qd_low;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
        end else begin
            mul_reg  <= start;
            fix_reg  <= mul_reg;
            done_reg <= fix_reg;
            if (fix_reg) begin
                rem_reg <= rem_calc;
            end
        end
        if (start) begin
            x_reg <= dividend;
        end
        if (mul_reg) begin
            prod_reg <= {{(KEY_WIDTH + 1){1'b0}}, x_reg} * {{KEY_WIDTH{1'b0}}, MAGIC};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/chained_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_core: hash table with separate chaining
// Insert, search and delete of unsigned keys over a bounded node pool.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents (from bit 0)            Handshake
//  s_       in         cmd[1:0], key[KEY_WIDTH-1:0], pad     tvalid/tready
//  m_       out        found, status[1:0], bucket[2:0], pad  tvalid/tready
//
// An item passes the remainder unit that finds its bucket (its operand,
// product and remainder registers), then a decide state, then a pop state
// for an insert or one walk step per chain node visited for a search or
// delete, and an emit state that loads the result. A full pool, an empty
// bucket or the unused command goes from decide straight to emit. Words are
// accepted only in the idle state.
// After reset the bucket head memory is cleared one bucket per cycle, and
// no word is accepted meanwhile.
// One item is worked on at a time; the next word is taken once the result
// has moved to the output register, even while that result is still stalled.
//
module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int BUCKETS     = DEF_BUCKETS,
    parameter int POOL_SIZE   = DEF_POOL_SIZE,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    localparam int S_TDATA_W  = ((2 + KEY_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cmd[1:0], key[KEY_WIDTH+1:2], zero padding above
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // found[0], status[2:1], bucket[5:3], zero padding above
    output logic [RES_W-1:0]     m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int BW   = $clog2(BUCKETS);         // bucket index
    localparam int PW   = $clog2(POOL_SIZE);       // node index
    localparam int LW   = $clog2(POOL_SIZE + 1);   // link, with end-of-chain
    localparam int CNTW = $clog2(POOL_SIZE + 1);   // free node count
    localparam logic [LW-1:0]   NIL       = LW'(POOL_SIZE);
    localparam logic [CNTW-1:0] POOL_FULL = CNTW'(POOL_SIZE);

    // Memories. Node keys and links are written before any chain reaches
    // them; the free stack has no reset, and its entries below the low-water mark are never used.
    logic [LW-1:0]        heads_mem [BUCKETS];
    logic [KEY_WIDTH-1:0] keys_mem  [POOL_SIZE];
    logic [LW-1:0]        links_mem [POOL_SIZE];
    logic [PW-1:0]        free_mem  [POOL_SIZE];

    state_t state_reg, state_next;

    logic                 s_accept;
    logic                 mod_done;
    logic [BW-1:0]        bucket;

    cmd_t                 cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [PW-1:0]        p_reg, p_next;
    logic [LW-1:0]        prev_reg, prev_next;
    logic [CNTW-1:0]      free_count_reg, free_count_next;
    logic [CNTW-1:0]      low_mark_reg, low_mark_next;
    logic [BW-1:0]        clr_reg, clr_next;
    logic                 res_found_reg, res_found_next;
    status_t              res_status_reg, res_status_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg;
    status_t              m_status_reg;
    logic [2:0]           m_bucket_reg;
    logic                 m_load;

    // Registered memory read data.
    logic [LW-1:0]        head_q;
    logic [KEY_WIDTH-1:0] key_q;
    logic [LW-1:0]        link_q;
    logic [PW-1:0]        free_q;

    // Memory write and read controls.
    logic                 heads_we;
    logic [BW-1:0]        heads_waddr;
    logic [LW-1:0]        heads_wdata;
    logic                 node_we;
    logic [PW-1:0]        node_waddr;
    logic                 links_we;
    logic [PW-1:0]        links_waddr;
    logic [LW-1:0]        links_wdata;
    logic                 free_we;
    logic [PW-1:0]        node_raddr;

    logic [CNTW-1:0]      pop_idx;
    logic                 pop_fresh;
    logic [PW-1:0]        pop_node;
    logic                 key_hit;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // The remainder holds the bucket from the end of hashing until the next
    // word is accepted.
    cht_mod_unit #(
        .KEY_WIDTH (KEY_WIDTH),
        .BUCKETS   (BUCKETS)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .dividend  (s_tdata[2 +: KEY_WIDTH]),
        .done      (mod_done),
        .remainder (bucket)
    );

    // Pops read the entry just below the count. An entry below the low-water
    // mark has never been pushed to, so its own index stands in for its contents.
    assign pop_idx   = free_count_reg - CNTW'(1);
    assign pop_fresh = (pop_idx < low_mark_reg);
    assign pop_node  = pop_fresh ? pop_idx[PW-1:0] : free_q;
    assign key_hit   = (key_q == key_reg);

    assign m_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        state_next = (free_count_reg == '0) ? ST_EMIT : ST_POP;
                    end
                    CMD_SEARCH, CMD_DELETE: begin
                        state_next = (head_q >= NIL) ? ST_EMIT : ST_WALK;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_POP: begin
                state_next = ST_EMIT;
            end
            ST_WALK: begin
                if (key_hit || (link_q >= NIL)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        p_next          = p_reg;
        prev_next       = prev_reg;
        free_count_next = free_count_reg;
        low_mark_next   = low_mark_reg;
        clr_next        = clr_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        heads_we        = 1'b0;
        heads_waddr     = bucket;
        heads_wdata     = NIL;
        node_we         = 1'b0;
        node_waddr      = pop_node;
        links_we        = 1'b0;
        links_waddr     = pop_node;
        links_wdata     = head_q;
        free_we         = 1'b0;
        node_raddr      = head_q[PW-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                heads_we    = 1'b1;
                heads_waddr = clr_reg;
                heads_wdata = NIL;
                clr_next    = clr_reg + BW'(1);
            end
            ST_DECIDE: begin
                res_found_next  = 1'b0;
                res_status_next = STAT_DONE;
                p_next          = head_q[PW-1:0];
                prev_next       = NIL;
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        if (free_count_reg == '0) begin
                            res_status_next = STAT_FULL;
                        end
                    end
                    CMD_SEARCH, CMD_DELETE: begin
                        if (head_q >= NIL) begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    end
                    default: begin
                        res_status_next = STAT_DONE;
                    end
                endcase
            end
            ST_POP: begin
                // New node goes to the head of its bucket's chain.
                node_we         = 1'b1;
                links_we        = 1'b1;
                heads_we        = 1'b1;
                heads_wdata     = LW'(pop_node);
                free_count_next = pop_idx;
                if (pop_fresh) begin
                    low_mark_next = pop_idx;
                end
            end
            ST_WALK: begin
                if (key_hit) begin
                    res_found_next = 1'b1;
                    if (cmd_reg == CMD_DELETE) begin
                        if (prev_reg >= NIL) begin
                            heads_we    = 1'b1;
                            heads_wdata = link_q;
                        end else begin
                            links_we    = 1'b1;
                            links_waddr = prev_reg[PW-1:0];
                            links_wdata = link_q;
                        end
                        if (free_count_reg < POOL_FULL) begin
                            free_we         = 1'b1;
                            free_count_next = free_count_reg + CNTW'(1);
                        end
                    end
                end else if (link_q >= NIL) begin
                    res_status_next = STAT_NOT_FOUND;
                end else begin
                    // Follow the link straight from the read data, one node
                    // per cycle.
                    prev_next  = LW'(p_reg);
                    p_next     = link_q[PW-1:0];
                    node_raddr = link_q[PW-1:0];
                end
            end
            default: begin
                node_raddr = head_q[PW-1:0];
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= POOL_FULL;
            low_mark_reg   <= POOL_FULL;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            low_mark_reg   <= low_mark_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_tdata[1:0];
            key_reg <= s_tdata[2 +: KEY_WIDTH];
        end
        p_reg          <= p_next;
        prev_reg       <= prev_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (m_load) begin
            m_found_reg  <= res_found_reg;
            m_status_reg <= res_status_reg;
            m_bucket_reg <= 3'(bucket);
        end
    end

    // Bucket head memory.
    always_ff @(posedge aclk) begin
        if (heads_we) begin
            heads_mem[heads_waddr] <= heads_wdata;
        end
        head_q <= heads_mem[bucket];
    end

    // Node key and link memories share a read address.
    always_ff @(posedge aclk) begin
        if (node_we) begin
            keys_mem[node_waddr] <= key_reg;
        end
        key_q <= keys_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (links_we) begin
            links_mem[links_waddr] <= links_wdata;
        end
        link_q <= links_mem[node_raddr];
    end

    // Free node stack.
    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_count_reg[PW-1:0]] <= p_reg;
        end
        free_q <= free_mem[pop_idx[PW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(RES_W - 6){1'b0}}, m_bucket_reg, m_status_reg, m_found_reg};

endmodule

// ===== test/cht_result_checker.sv =====
// ----------------------------------------------------------------------------
// cht_result_checker: result checker for the chained hash table
// Watches both channels, keeps its own copy of the table, predicts the answer
// to every accepted command word and compares each result word with it.
// ----------------------------------------------------------------------------
module cht_result_checker
    import cht_pkg::*;
#(
    parameter int BUCKETS   = DEF_BUCKETS,
    parameter int POOL_SIZE = DEF_POOL_SIZE,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int S_TDATA_W = ((2 + KEY_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cmd[1:0], key[KEY_WIDTH+1:2], zero padding above
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // found[0], status[2:1], bucket[5:3], zero padding above
    input  logic [RES_W-1:0]     m_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    output int                   mismatches,
    output int                   pending_results,
    output int                   results_checked,
    output int                   hit_count,
    output int                   miss_count,
    output int                   full_count
);

    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam int SLOT_W = $clog2(POOL_SIZE);

    typedef struct packed {
        logic       found;
        status_t    status;
        logic [2:0] bucket;
    } answer_t;

    // Shadow copy of the table. A link or head equal to POOL_SIZE ends a chain.
    logic [LINK_W-1:0]    chain_head [BUCKETS];
    logic [KEY_WIDTH-1:0] node_key   [POOL_SIZE];
    logic [LINK_W-1:0]    node_next  [POOL_SIZE];
    logic [SLOT_W-1:0]    free_slots [POOL_SIZE];
    int unsigned          free_total;

    answer_t answer_queue [$];

    task automatic clear_table();
        for (int i = 0; i < BUCKETS; i++) begin
            chain_head[i] = LINK_W'(POOL_SIZE);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            node_key[i]   = '0;
            node_next[i]  = LINK_W'(POOL_SIZE);
            free_slots[i] = SLOT_W'(i);
        end
        free_total = POOL_SIZE;
    endtask

    // Applies one command to the shadow table and returns its answer.
    task automatic table_apply(input cmd_t cmd, input logic [KEY_WIDTH-1:0] key,
                               output answer_t ans);
        int b;
        int node;
        int prev;
        int steps;
        b          = int'(key % KEY_WIDTH'(BUCKETS));
        ans.found  = 1'b0;
        ans.status = STAT_DONE;
        ans.bucket = 3'(b);
        case (cmd)
            CMD_INSERT: begin
                if (free_total == 0) begin
                    ans.status = STAT_FULL;
                end else begin
                    free_total--;
                    node            = int'(free_slots[free_total]);
                    node_key[node]  = key;
                    node_next[node] = chain_head[b];
                    chain_head[b]   = LINK_W'(node);
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                prev  = POOL_SIZE;
                node  = int'(chain_head[b]);
                steps = 0;
                while (node < POOL_SIZE && steps < POOL_SIZE && node_key[node] != key) begin
                    prev  = node;
                    node  = int'(node_next[node]);
                    steps++;
                end
                if (node < POOL_SIZE && steps < POOL_SIZE) begin
                    ans.found = 1'b1;
                    if (cmd == CMD_DELETE) begin
                        // The first match nearest the head is unlinked.
                        if (prev >= POOL_SIZE) begin
                            chain_head[b] = node_next[node];
                        end else begin
                            node_next[prev] = node_next[node];
                        end
                        node_next[node] = LINK_W'(POOL_SIZE);
                        if (free_total < POOL_SIZE) begin
                            free_slots[free_total] = SLOT_W'(node);
                            free_total++;
                        end
                    end
                end else begin
                    ans.status = STAT_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", results_checked, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        answer_t ans;
        if (!aresetn) begin
            clear_table();
            answer_queue.delete();
        end else begin
            // A result always belongs to an earlier command, so pop first.
            if (m_tvalid && m_tready) begin
                got.found  = m_tdata[0];
                got.status = m_tdata[2:1];
                got.bucket = m_tdata[5:3];
                if (answer_queue.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no command waiting",
                                              m_tdata));
                end else begin
                    want = answer_queue.pop_front();
                    if (got.found != want.found) begin
                        report_mismatch($sformatf("found %0d, expected %0d",
                                                  got.found, want.found));
                    end
                    if (got.status != want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    end
                    if (got.bucket != want.bucket) begin
                        report_mismatch($sformatf("bucket %0d, expected %0d",
                                                  got.bucket, want.bucket));
                    end
                    results_checked++;
                    if (want.found) hit_count++;
                    if (want.status == STAT_NOT_FOUND) miss_count++;
                    if (want.status == STAT_FULL) full_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                table_apply(s_tdata[1:0], s_tdata[KEY_WIDTH+1:2], ans);
                answer_queue.push_back(ans);
            end
        end
        pending_results <= answer_queue.size();
    end

endmodule

// ===== test/chained_hash_table_core_test.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_core_test: testbench of the chained hash table core
// Drives command words into the table under varying idle and stall patterns;
// a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module chained_hash_table_core_test;
    import cht_pkg::*;

    localparam int BUCKETS      = DEF_BUCKETS;
    localparam int POOL_SIZE    = DEF_POOL_SIZE;
    localparam int KEY_W        = DEF_KEY_WIDTH;
    localparam int IN_W         = ((2 + KEY_W + 7) / 8) * 8;
    localparam int CLK_PERIOD   = 10;

    // The one command code that the block treats as a no-op.
    localparam cmd_t CMD_UNUSED = 2'd3;

    // Even the slowest item walks no more than the whole pool, so a full run of
    // random words stays far below this watchdog limit.
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = KEY_W + POOL_SIZE + 16;
    localparam int RANDOM_ITEMS = 1130;
    localparam int PROFILE_SPAN = 60;
    localparam int LONG_HOLD    = 1500;
    localparam int HOLD_AT      = 400;
    localparam int POOL_KEYS    = 16;

    typedef enum {
        MODE_FILL,
        MODE_MIX,
        MODE_DRAIN
    } burst_mode_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tvalid = 1'b0;
    wire              s_tready;
    wire  [RES_W-1:0] m_tdata;
    wire              m_tvalid;
    logic             m_tready = 1'b0;

    // Idle percentages of the current phase, and the request for one long
    // receiver hold-off.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;

    int cycle_count   = 0;
    int words_sent    = 0;
    int cmd_tally [4] = '{0, 0, 0, 0};

    // Working set of keys for the random part. Reusing a small set is what
    // makes searches and deletes find something and chains grow long.
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    int mismatches;
    int pending_results;
    int results_checked;
    int hit_count;
    int miss_count;
    int full_count;

    chained_hash_table_core #(
        .BUCKETS  (BUCKETS),
        .POOL_SIZE(POOL_SIZE),
        .KEY_WIDTH(KEY_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    cht_result_checker #(
        .BUCKETS  (BUCKETS),
        .POOL_SIZE(POOL_SIZE),
        .KEY_WIDTH(KEY_W),
        .S_TDATA_W(IN_W)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .mismatches     (mismatches),
        .pending_results(pending_results),
        .results_checked(results_checked),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .full_count     (full_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver. It stalls at the rate of the current phase, except for one
    // long hold-off, counted here, that lets the block fill up and stall its
    // input while the sender keeps offering words.
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Phase patterns: none, sender idle, receiver stalling, then both.
    task automatic set_idle_profile(input int profile);
        case (profile)
            0: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
            1: begin
                send_idle_pct  <= 64;
                recv_stall_pct <= 0;
            end
            2: begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 64;
            end
            default: begin
                send_idle_pct  <= 13;
                recv_stall_pct <= 13;
            end
        endcase
    endtask

    // Offers one command word and returns at the edge that accepts it. The
    // valid stays high into the next word when no idle cycle is drawn.
    task automatic send_word(input cmd_t cmd, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= IN_W'({key, cmd});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        cmd_tally[cmd]++;
    endtask

    // The count of waiting results is registered and lags an accept, so the
    // task waits on the clock before it first trusts the count.
    task automatic wait_for_results();
        do @(posedge aclk); while (pending_results != 0);
    endtask

    // Replaces a few keys of the working set. About half are fully random,
    // the rest crowd into one bucket so that long chains form.
    task automatic refresh_keys(input int count);
        int crowd;
        int idx;
        crowd = $urandom_range(BUCKETS - 1);
        for (int i = 0; i < count; i++) begin
            idx = $urandom_range(POOL_KEYS - 1);
            if ($urandom_range(1)) begin
                key_pool[idx] = KEY_W'($urandom());
            end else begin
                key_pool[idx] = KEY_W'($urandom_range(600) * BUCKETS + crowd);
            end
        end
    endtask

    // One random word whose command mix follows the burst mode. A small
    // share is noise: any command code, the unused one included, and any key.
    task automatic send_random_word(input burst_mode_t mode);
        int               roll;
        int               ins_top;
        int               srch_top;
        int               del_top;
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        case (mode)
            MODE_FILL: begin
                ins_top = 82; srch_top = 92; del_top = 95;
            end
            MODE_MIX: begin
                ins_top = 35; srch_top = 65; del_top = 93;
            end
            default: begin
                ins_top = 8;  srch_top = 28; del_top = 93;
            end
        endcase
        roll = $urandom_range(99);
        key  = key_pool[$urandom_range(POOL_KEYS - 1)];
        if (roll < ins_top) begin
            cmd = CMD_INSERT;
        end else if (roll < srch_top) begin
            cmd = CMD_SEARCH;
        end else if (roll < del_top) begin
            cmd = CMD_DELETE;
        end else begin
            cmd = cmd_t'($urandom_range(3));
            key = KEY_W'($urandom());
        end
        send_word(cmd, key);
    endtask

    initial begin
        int          rand_done;
        int          episode;
        int          burst_len;
        int          roll;
        burst_mode_t mode;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words, no idling. They touch empty buckets, both key
        // extremes, duplicate keys, hits at the head, in the middle and at
        // the tail of a chain, a miss in a bucket that is not empty, and the
        // unused command code.
        send_word(CMD_SEARCH, '0);
        send_word(CMD_DELETE, KEY_W'(5));
        send_word(CMD_INSERT, '0);
        send_word(CMD_INSERT, '1);
        send_word(CMD_SEARCH, '1);
        send_word(CMD_SEARCH, '0);
        send_word(CMD_INSERT, KEY_W'(7));
        send_word(CMD_INSERT, KEY_W'(14));
        send_word(CMD_INSERT, KEY_W'(7));
        send_word(CMD_SEARCH, '0);
        send_word(CMD_DELETE, KEY_W'(7));
        send_word(CMD_SEARCH, KEY_W'(7));
        send_word(CMD_DELETE, KEY_W'(7));
        send_word(CMD_DELETE, KEY_W'(7));
        send_word(CMD_DELETE, '0);
        send_word(CMD_SEARCH, KEY_W'(21));
        send_word(CMD_INSERT, KEY_W'(6));
        send_word(CMD_DELETE, KEY_W'(6));
        send_word(CMD_UNUSED, '1);
        send_word(CMD_UNUSED, '0);
        send_word(CMD_SEARCH, KEY_W'(14));
        send_word(CMD_DELETE, KEY_W'(14));
        send_word(CMD_DELETE, '1);

        // Random part: bursts that fill the pool past full, mix operations,
        // or drain it again, over a slowly changing working set of keys.
        refresh_keys(POOL_KEYS);
        rand_done = 0;
        episode   = 0;
        while (rand_done < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            if (episode % 5 == 0 || roll < 30) begin
                mode = MODE_FILL;
            end else if (roll < 70) begin
                mode = MODE_MIX;
            end else begin
                mode = MODE_DRAIN;
            end
            burst_len = (mode == MODE_FILL) ? 90 : $urandom_range(40, 90);
            refresh_keys(4);
            for (int i = 0; i < burst_len && rand_done < RANDOM_ITEMS; i++) begin
                if (rand_done % PROFILE_SPAN == 0) begin
                    set_idle_profile((rand_done / PROFILE_SPAN) % 4);
                end
                // The sender keeps offering with no gaps while the receiver
                // sits out its long hold-off.
                if (rand_done == HOLD_AT) begin
                    set_idle_profile(0);
                    hold_req <= 1'b1;
                end
                send_random_word(mode);
                rand_done++;
            end
            // Every third burst the sender pauses until the table has
            // answered everything it was sent.
            if (episode % 3 == 2) begin
                s_tvalid <= 1'b0;
                wait_for_results();
            end
            episode++;
        end
        s_tvalid <= 1'b0;

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Summary: %0d words sent (%0d insert, %0d search, %0d delete, %0d unused).",
                 words_sent, cmd_tally[CMD_INSERT], cmd_tally[CMD_SEARCH],
                 cmd_tally[CMD_DELETE], cmd_tally[CMD_UNUSED]);
        $display("Summary: %0d results checked: %0d hits, %0d misses, %0d pool-full rejects.",
                 results_checked, hit_count, miss_count, full_count);
        if (mismatches == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
